[hdl/dfd_pkg.sv]
package dfd_pkg;

  localparam int unsigned IndexBits = 9;
  localparam int unsigned RemainBits = 9;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 8;

  localparam logic [7:0] IdleTimeoutReset = 8'd100;
  localparam logic [7:0] ModuleStartReset = 8'h02;
  localparam logic [7:0] ModuleEndReset = 8'h03;
  localparam logic [7:0] HostStartReset = 8'h55;
  localparam logic [7:0] HostEndReset = 8'hAA;

  localparam logic [7:0] IdleMax = 8'hFF;
  localparam logic [RemainBits-1:0] RemainReset = RemainBits'(8'hFF);
  localparam logic [IndexBits-1:0] LenPosA = IndexBits'(2);
  localparam logic [IndexBits-1:0] LenPosB = IndexBits'(1);
  localparam logic [RemainBits-1:0] ExtraA = RemainBits'(4);
  localparam logic [RemainBits-1:0] ExtraB = RemainBits'(3);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_IDLE_TIMEOUT = 3'd0,
    CFG_MODULE_START = 3'd1,
    CFG_MODULE_END   = 3'd2,
    CFG_HOST_START   = 3'd3,
    CFG_HOST_END     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_BODY    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BAD_END = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MODE_HUNT = 3'b001,
    MODE_A    = 3'b010,
    MODE_B    = 3'b100
  } mode_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [IndexBits-1:0] byte_index;
    logic                 frame_kind;
    logic                 last;
    status_e              status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] idle_timeout_ticks;
    logic [7:0] module_start_byte;
    logic [7:0] module_end_byte;
    logic [7:0] host_start_byte;
    logic [7:0] host_end_byte;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

[hdl/dfd_cfg.sv]
module dfd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dfd_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [dfd_pkg::CfgDataBits-1:0]  cfg_data_i,
  output dfd_pkg::cfg_t                    cfg_o
);

  dfd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfd_pkg::CFG_IDLE_TIMEOUT: cfg_d.idle_timeout_ticks = cfg_data_i;
        dfd_pkg::CFG_MODULE_START: cfg_d.module_start_byte = cfg_data_i;
        dfd_pkg::CFG_MODULE_END:   cfg_d.module_end_byte = cfg_data_i;
        dfd_pkg::CFG_HOST_START:   cfg_d.host_start_byte = cfg_data_i;
        dfd_pkg::CFG_HOST_END:     cfg_d.host_end_byte = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout_ticks <= dfd_pkg::IdleTimeoutReset;
      cfg_q.module_start_byte <= dfd_pkg::ModuleStartReset;
      cfg_q.module_end_byte <= dfd_pkg::ModuleEndReset;
      cfg_q.host_start_byte <= dfd_pkg::HostStartReset;
      cfg_q.host_end_byte <= dfd_pkg::HostEndReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/dfd_core.sv]
module dfd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dfd_pkg::in_item_t in_item_i,
  input  dfd_pkg::cfg_t     cfg_i,
  input  logic              slot_free_i,
  output dfd_pkg::res_t     res_o
);

  logic                                in_valid_q, in_valid_d;
  dfd_pkg::in_item_t                   in_item_q;
  logic                                accept, advance;

  dfd_pkg::mode_e                      mode_q, mode_d;
  logic [dfd_pkg::IndexBits-1:0]       taken_q, taken_d;
  logic [dfd_pkg::RemainBits-1:0]      remain_q, remain_d;
  logic [7:0]                          idle_q, idle_d;

  logic                                in_frame, kind;
  logic [7:0]                          idle_inc, end_byte;
  logic [dfd_pkg::IndexBits-1:0]       len_pos;
  logic [dfd_pkg::RemainBits-1:0]      extra, rem_base, rem_dec;
  dfd_pkg::res_t                       res;

  // input register: holds one item until the result slot can take its outcome
  assign advance    = in_valid_q && slot_free_i;
  assign in_stall_o = in_valid_q && !slot_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  assign in_frame = (mode_q == dfd_pkg::MODE_A) || (mode_q == dfd_pkg::MODE_B);
  assign kind     = (mode_q == dfd_pkg::MODE_B);
  assign idle_inc = (idle_q == dfd_pkg::IdleMax) ? idle_q : idle_q + 8'd1;
  assign len_pos  = kind ? dfd_pkg::LenPosB : dfd_pkg::LenPosA;
  assign extra    = kind ? dfd_pkg::ExtraB : dfd_pkg::ExtraA;
  assign end_byte = kind ? cfg_i.host_end_byte : cfg_i.module_end_byte;
  // length byte reloads the remaining count
  assign rem_base = (taken_q == len_pos)
                    ? ({1'b0, in_item_q.rx_byte} + extra) : remain_q;
  assign rem_dec  = rem_base - dfd_pkg::RemainBits'(1);

  always_comb begin
    mode_d   = mode_q;
    taken_d  = taken_q;
    remain_d = remain_q;
    idle_d   = idle_q;
    res      = '0;
    res.item.frame_kind = kind;
    res.item.byte_index = taken_q;
    if (advance) begin
      if (in_item_q.func) begin
        if (in_frame) begin
          if (idle_inc > cfg_i.idle_timeout_ticks) begin
            res.valid         = 1'b1;
            res.item.out_byte = 8'd0;
            res.item.last     = 1'b1;
            res.item.status   = dfd_pkg::ST_TIMEOUT;
            mode_d   = dfd_pkg::MODE_HUNT;
            taken_d  = '0;
            remain_d = dfd_pkg::RemainReset;
            idle_d   = '0;
          end else begin
            idle_d = idle_inc;
          end
        end
      end else begin
        idle_d = '0;
        if (!in_frame) begin
          if (in_item_q.rx_byte == cfg_i.module_start_byte) begin
            mode_d = dfd_pkg::MODE_A;
          end else if (in_item_q.rx_byte == cfg_i.host_start_byte) begin
            mode_d = dfd_pkg::MODE_B;
          end
        end else begin
          res.valid         = 1'b1;
          res.item.out_byte = in_item_q.rx_byte;
          if (rem_dec == '0) begin
            res.item.last   = 1'b1;
            res.item.status = (in_item_q.rx_byte == end_byte)
                              ? dfd_pkg::ST_GOOD : dfd_pkg::ST_BAD_END;
            mode_d   = dfd_pkg::MODE_HUNT;
            taken_d  = '0;
            remain_d = dfd_pkg::RemainReset;
          end else begin
            res.item.last   = 1'b0;
            res.item.status = dfd_pkg::ST_BODY;
            taken_d  = taken_q + dfd_pkg::IndexBits'(1);
            remain_d = rem_dec;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dfd_pkg::MODE_HUNT;
      taken_q  <= '0;
      remain_q <= dfd_pkg::RemainReset;
      idle_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      taken_q  <= taken_d;
      remain_q <= remain_d;
      idle_q   <= idle_d;
    end
  end

  assign res_o = res;

  // counters are back at reset values whenever hunting
  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == dfd_pkg::MODE_HUNT) |->
      (taken_q == '0 && remain_q == dfd_pkg::RemainReset && idle_q == '0))
    else $error("counters not cleared while hunting");

  a_idle_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_q != '0) |-> in_frame)
    else $error("idle count running outside a frame");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.item.status != dfd_pkg::ST_BODY) |-> res.item.last)
    else $error("frame end without last flag");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)))
    else $error("pending input item lost");

endmodule

[hdl/dfd_outreg.sv]
module dfd_outreg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfd_pkg::res_t      res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dfd_pkg::out_item_t out_item_o
);

  logic               out_valid_q, out_valid_d;
  dfd_pkg::out_item_t out_item_q;

  assign slot_free_o = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_i.valid ? 1'b1 : (slot_free_o ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      out_item_q <= res_i.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/dual_format_uart_deframer.sv]
// an accepted item gives its result, if any, by way of the input register
// and then the result register
// throughput: one item per cycle while results are taken; a held result
// stalls the input register, which still takes one more item
// reset: asynchronous active low, back to hunting with registers at defaults
module dual_format_uart_deframer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dfd_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dfd_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [dfd_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [dfd_pkg::CfgDataBits-1:0]  cfg_data_i
);

  dfd_pkg::cfg_t cfg;
  dfd_pkg::res_t res;
  logic          slot_free;

  dfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .slot_free_i (slot_free),
    .res_o       (res)
  );

  dfd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[sim/tb_dual_format_uart_deframer.sv]
`timescale 1ns / 1ps

module tb_dual_format_uart_deframer;

  localparam logic FuncByte = 1'b0;
  localparam logic FuncTick = 1'b1;
  localparam logic KindModule = 1'b0;
  localparam logic KindHost = 1'b1;
  localparam int SettleCycles = 6;
  localparam int RandomPhases = 5;
  localparam int PhaseBudget = 165;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dfd_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dfd_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [dfd_pkg::CfgIdxBits-1:0] cfg_idx = '0;
  logic [dfd_pkg::CfgDataBits-1:0] cfg_data = '0;

  dual_format_uart_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // deframer shadow state
  dfd_pkg::cfg_t regs = '{dfd_pkg::IdleTimeoutReset, dfd_pkg::ModuleStartReset,
                          dfd_pkg::ModuleEndReset, dfd_pkg::HostStartReset,
                          dfd_pkg::HostEndReset};
  dfd_pkg::mode_e parse_st = dfd_pkg::MODE_HUNT;
  logic [dfd_pkg::IndexBits-1:0] taken_cnt = '0;
  logic [dfd_pkg::RemainBits-1:0] remain_cnt = dfd_pkg::RemainReset;
  logic [7:0] idle_cnt = '0;

  dfd_pkg::in_item_t rx_stream_q[$];
  dfd_pkg::out_item_t frame_events_q[$];
  int errors = 0;
  int pushed_cnt = 0;

  function automatic void clear_frame();
    parse_st = dfd_pkg::MODE_HUNT;
    taken_cnt = '0;
    remain_cnt = dfd_pkg::RemainReset;
    idle_cnt = '0;
  endfunction

  function automatic void deframe_item(dfd_pkg::in_item_t it);
    dfd_pkg::out_item_t ev;
    logic kind;
    logic [dfd_pkg::IndexBits-1:0] len_pos;
    logic [dfd_pkg::RemainBits-1:0] extra;
    logic [7:0] end_byte;
    logic [dfd_pkg::IndexBits-1:0] idx;
    bit in_frame;
    in_frame = (parse_st == dfd_pkg::MODE_A) || (parse_st == dfd_pkg::MODE_B);
    kind = (parse_st == dfd_pkg::MODE_B) ? KindHost : KindModule;
    if (it.func == FuncTick) begin
      if (!in_frame) return;
      if (idle_cnt != dfd_pkg::IdleMax) idle_cnt++;
      if (idle_cnt > regs.idle_timeout_ticks) begin
        ev.out_byte = '0;
        ev.byte_index = taken_cnt;
        ev.frame_kind = kind;
        ev.last = 1'b1;
        ev.status = dfd_pkg::ST_TIMEOUT;
        frame_events_q.push_back(ev);
        clear_frame();
      end
      return;
    end
    idle_cnt = '0;
    if (!in_frame) begin
      // type A is checked first, so it wins on equal start bytes
      if (it.rx_byte == regs.module_start_byte) parse_st = dfd_pkg::MODE_A;
      else if (it.rx_byte == regs.host_start_byte) parse_st = dfd_pkg::MODE_B;
      return;
    end
    len_pos = (kind == KindHost) ? dfd_pkg::LenPosB : dfd_pkg::LenPosA;
    extra = (kind == KindHost) ? dfd_pkg::ExtraB : dfd_pkg::ExtraA;
    end_byte = (kind == KindHost) ? regs.host_end_byte : regs.module_end_byte;
    idx = taken_cnt;
    if (idx == len_pos) remain_cnt = dfd_pkg::RemainBits'(it.rx_byte) + extra;
    remain_cnt = remain_cnt - 1'b1;
    taken_cnt = taken_cnt + 1'b1;
    ev.out_byte = it.rx_byte;
    ev.byte_index = idx;
    ev.frame_kind = kind;
    if (remain_cnt == '0) begin
      ev.last = 1'b1;
      ev.status = (it.rx_byte == end_byte) ? dfd_pkg::ST_GOOD : dfd_pkg::ST_BAD_END;
      clear_frame();
    end else begin
      ev.last = 1'b0;
      ev.status = dfd_pkg::ST_BODY;
    end
    frame_events_q.push_back(ev);
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) deframe_item(in_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_stream_q.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= rx_stream_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between calm, choppy and long holds
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run = 0;

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : mon
    dfd_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (frame_events_q.size() == 0) begin
          $error("item with no prediction: %p", out_item);
          errors++;
        end else begin
          want = frame_events_q.pop_front();
          check_field("out_byte", want.out_byte, out_item.out_byte);
          check_field("byte_index", want.byte_index, out_item.byte_index);
          check_field("frame_kind", want.frame_kind, out_item.frame_kind);
          check_field("last", want.last, out_item.last);
          check_field("status", want.status, out_item.status);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 4);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else begin
            if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 15);
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  task automatic push_byte(logic [7:0] b, bit counted);
    dfd_pkg::in_item_t it;
    it.func = FuncByte;
    it.rx_byte = b;
    rx_stream_q.push_back(it);
    if (counted) pushed_cnt++;
  endtask

  task automatic push_tick(bit counted);
    dfd_pkg::in_item_t it;
    it.func = FuncTick;
    it.rx_byte = 8'($urandom_range(0, 255));
    rx_stream_q.push_back(it);
    if (counted) pushed_cnt++;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 12);
    if (r < 97) return $urandom_range(13, 60);
    return $urandom_range(200, 255);
  endfunction

  // one frame; a broken one stops early and may be left to time out
  task automatic push_frame(logic kind, int len, bit good, bit broken);
    int body_n;
    int len_pos;
    int cut;
    int tmo;
    logic [7:0] end_byte;
    logic [7:0] b;
    body_n = len + ((kind == KindHost) ? 4 : 6);
    len_pos = (kind == KindHost) ? 1 : 2;
    end_byte = (kind == KindHost) ? regs.host_end_byte : regs.module_end_byte;
    cut = broken ? $urandom_range(0, body_n - 1) : body_n;
    tmo = regs.idle_timeout_ticks;
    push_byte((kind == KindHost) ? regs.host_start_byte : regs.module_start_byte, 1'b1);
    for (int i = 0; i < cut; i++) begin
      if (i == len_pos) b = 8'(len);
      else if (i == body_n - 1) b = good ? end_byte : end_byte ^ 8'($urandom_range(1, 255));
      else b = 8'($urandom_range(0, 255));
      push_byte(b, 1'b1);
      // idle ticks short of the timeout keep the frame open
      if (i < body_n - 1 && tmo > 0 && $urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, (tmo < 4) ? tmo : 4)) push_tick(1'b1);
    end
    if (broken && tmo < 64) repeat (tmo + 1) push_tick(1'b1);
  endtask

  task automatic random_traffic(int budget);
    int start;
    int r;
    start = pushed_cnt;
    while (pushed_cnt - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 72)
        push_frame(1'($urandom_range(0, 1)), pick_len(), $urandom_range(0, 3) != 0, 1'b0);
      else if (r < 84)
        push_frame(1'($urandom_range(0, 1)), pick_len(), 1'b1, 1'b1);
      else if (r < 94)
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      else repeat ($urandom_range(1, 4)) push_tick(1'b0);
    end
    // when the timeout is below 64, close any frame left open so the next settings start from hunting
    if (regs.idle_timeout_ticks < 64) repeat (regs.idle_timeout_ticks + 1) push_tick(1'b1);
  endtask

  task automatic wait_quiet();
    while (rx_stream_q.size() != 0 || in_valid || frame_events_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dfd_pkg::CfgIdxBits-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
  endtask

  task automatic load_regs(dfd_pkg::cfg_t c, bit with_unused);
    write_reg(dfd_pkg::CFG_IDLE_TIMEOUT, c.idle_timeout_ticks);
    write_reg(dfd_pkg::CFG_MODULE_START, c.module_start_byte);
    write_reg(dfd_pkg::CFG_MODULE_END, c.module_end_byte);
    write_reg(dfd_pkg::CFG_HOST_START, c.host_start_byte);
    write_reg(dfd_pkg::CFG_HOST_END, c.host_end_byte);
    if (with_unused)
      for (int k = int'(dfd_pkg::CFG_HOST_END) + 1; k < (1 << dfd_pkg::CfgIdxBits); k++)
        write_reg(dfd_pkg::CfgIdxBits'(k), 8'($urandom_range(0, 255)));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    regs = c;
    @(negedge clk_i);
  endtask

  initial begin
    dfd_pkg::cfg_t c;
    clear_frame();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: idle and stray byte while hunting, then both frame types
    push_tick(1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(regs.module_start_byte, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(regs.module_end_byte, 1'b1);
    push_byte(regs.host_start_byte, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(regs.host_start_byte, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h01, 1'b1);
    push_tick(1'b1);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b1);
    push_byte(regs.host_end_byte, 1'b1);
    wait_quiet();

    // equal start bytes, zero timeout: drop after one body byte
    c = '{8'h00, 8'h7E, 8'h00, 8'h7E, 8'hFF};
    load_regs(c, 1'b1);
    push_byte(8'h7E, 1'b1);
    push_byte(8'h11, 1'b1);
    push_tick(1'b1);
    push_byte(8'h7E, 1'b1);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h55, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h02, 1'b1);
    push_byte(8'h00, 1'b1);
    wait_quiet();

    for (int p = 0; p < RandomPhases; p++) begin
      c = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      case (p)
        0: begin
          c.idle_timeout_ticks = 8'd3;
          c.module_end_byte = 8'h00;
          c.host_end_byte = 8'hFF;
          if (c.host_start_byte == c.module_start_byte) c.host_start_byte ^= 8'h01;
        end
        1: begin
          c.idle_timeout_ticks = 8'hFF;
          c.module_start_byte = 8'hFF;
          c.host_start_byte = 8'h00;
        end
        2: begin
          c.idle_timeout_ticks = 8'($urandom_range(1, 20));
          c.host_start_byte = c.module_start_byte;
        end
        3: ;
        default: c = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
      endcase
      load_regs(c, 1'b0);
      if (p == 1) begin
        // idle count saturates, so the frame survives a long silence
        push_byte(regs.module_start_byte, 1'b1);
        push_byte(8'h01, 1'b1);
        repeat (300) push_tick(1'b1);
        repeat (4) push_byte(8'h00, 1'b1);
        push_byte(regs.module_end_byte, 1'b1);
      end
      random_traffic(PhaseBudget);
      wait_quiet();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0 && frame_events_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
